@@ hw/rtl/smrb_pkg.sv @@
`default_nettype none

package smrb_pkg;

    // receive fifo geometry
    localparam int RX_DEPTH = 8;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);

    // register offsets in the 0x4000-byte window
    localparam logic [13:0] OFS_CR0    = 14'h0000;
    localparam logic [13:0] OFS_CR1    = 14'h0004;
    localparam logic [13:0] OFS_DATA   = 14'h0008;
    localparam logic [13:0] OFS_STATUS = 14'h000C;
    localparam logic [13:0] OFS_CPSR   = 14'h0010;
    localparam logic [13:0] OFS_IMSC   = 14'h0014;
    localparam logic [13:0] OFS_RIS    = 14'h0018;
    localparam logic [13:0] OFS_MIS    = 14'h001C;
    localparam logic [13:0] OFS_ICR    = 14'h0020;
    localparam logic [13:0] OFS_DMACR  = 14'h0024;

    // access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [31:0] CR0_RESET     = 32'h0000_0007;
    localparam logic [31:0] STATUS_FIXED  = 32'h0000_0003;
    localparam logic [31:0] RX_INT_BIT    = 32'h0000_0004;
    localparam logic [15:0] RX_PUSH_VALUE = 16'h0000;

    // one bus access
    typedef struct packed {
        logic        mode;
        logic [13:0] offset;
        logic [31:0] write_data;
    } req_t;

    // one result word
    typedef struct packed {
        logic [31:0] read_data;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        rx_overrun;
        logic        unmodelled;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/smrb_regfile.sv @@
`default_nettype none

module smrb_regfile (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire smrb_pkg::req_t req,
    output smrb_pkg::res_t     res_first,
    output smrb_pkg::res_t     res_second,
    output logic               two_results
);

    logic [31:0] cr0_reg, cr0_next;
    logic [31:0] cr1_reg, cr1_next;
    logic [31:0] cpsr_reg, cpsr_next;
    logic [31:0] imsc_reg, imsc_next;
    logic [31:0] icr_reg, icr_next;
    logic [31:0] dmacr_reg, dmacr_next;

    logic [15:0] store_reg [smrb_pkg::RX_DEPTH];
    logic [smrb_pkg::RX_AW-1:0] head_reg, head_next;
    logic [smrb_pkg::RX_CW-1:0] count_reg, count_next;

    logic                       not_empty;
    logic                       full;
    logic [smrb_pkg::RX_CW:0]   tail_sum;
    logic [smrb_pkg::RX_CW:0]   tail_wrap;
    logic [smrb_pkg::RX_AW-1:0] tail_idx;
    logic                       push;
    logic                       pop;
    logic [31:0]                rd;
    logic                       um;
    logic                       is_data_wr;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == smrb_pkg::RX_CW'(smrb_pkg::RX_DEPTH));

    // tail = (head + count) mod depth, sum stays below twice the depth
    assign tail_sum  = (smrb_pkg::RX_CW+1)'(head_reg) + (smrb_pkg::RX_CW+1)'(count_reg);
    assign tail_wrap = (tail_sum >= (smrb_pkg::RX_CW+1)'(smrb_pkg::RX_DEPTH))
                     ? tail_sum - (smrb_pkg::RX_CW+1)'(smrb_pkg::RX_DEPTH)
                     : tail_sum;
    assign tail_idx  = tail_wrap[smrb_pkg::RX_AW-1:0];

    assign is_data_wr = (req.mode == smrb_pkg::MODE_WRITE) && (req.offset == smrb_pkg::OFS_DATA);

    always_comb
    begin
        cr0_next   = cr0_reg;
        cr1_next   = cr1_reg;
        cpsr_next  = cpsr_reg;
        imsc_next  = imsc_reg;
        icr_next   = icr_reg;
        dmacr_next = dmacr_reg;
        rd         = '0;
        um         = 1'b0;
        pop        = 1'b0;
        if (req.mode == smrb_pkg::MODE_READ)
        begin
            case (req.offset)
                smrb_pkg::OFS_CR0:    rd = cr0_reg;
                smrb_pkg::OFS_CR1:    rd = cr1_reg;
                smrb_pkg::OFS_DATA:
                begin
                    pop = not_empty;
                    rd  = not_empty ? {16'h0000, store_reg[head_reg]} : '0;
                end
                smrb_pkg::OFS_STATUS: rd = smrb_pkg::STATUS_FIXED
                                         | {28'h0, full, not_empty, 2'b00};
                smrb_pkg::OFS_CPSR:   rd = cpsr_reg;
                smrb_pkg::OFS_IMSC:   rd = imsc_reg;
                smrb_pkg::OFS_RIS:    rd = not_empty ? smrb_pkg::RX_INT_BIT : '0;
                smrb_pkg::OFS_MIS:    rd = (not_empty ? smrb_pkg::RX_INT_BIT : '0) & imsc_reg;
                smrb_pkg::OFS_ICR:    rd = icr_reg;
                smrb_pkg::OFS_DMACR:  rd = dmacr_reg;
                default:              um = 1'b1;
            endcase
        end
        else
        begin
            case (req.offset)
                smrb_pkg::OFS_CR0:   cr0_next   = req.write_data;
                smrb_pkg::OFS_CR1:   cr1_next   = req.write_data;
                smrb_pkg::OFS_DATA:  ;
                smrb_pkg::OFS_CPSR:  cpsr_next  = req.write_data;
                smrb_pkg::OFS_IMSC:  imsc_next  = req.write_data;
                smrb_pkg::OFS_ICR:   icr_next   = req.write_data;
                smrb_pkg::OFS_DMACR: dmacr_next = req.write_data;
                default:             um = 1'b1;
            endcase
        end
    end

    assign push = is_data_wr && !full;

    // fifo pointers
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
            head_next  = (head_reg == smrb_pkg::RX_AW'(smrb_pkg::RX_DEPTH - 1))
                       ? '0 : head_reg + 1'b1;
        end
    end

    // result words; frames wider than 8 bits go out high byte first
    always_comb
    begin
        two_results = is_data_wr && cr0_reg[3];
        res_first  = '0;
        res_second = '0;
        if (is_data_wr)
        begin
            res_first.byte_valid = 1'b1;
            if (two_results)
            begin
                res_first.out_byte    = req.write_data[15:8];
                res_second.out_byte   = req.write_data[7:0];
                res_second.byte_valid = 1'b1;
                res_second.rx_overrun = full;
                res_second.last       = 1'b1;
            end
            else
            begin
                res_first.out_byte   = req.write_data[7:0];
                res_first.rx_overrun = full;
                res_first.last       = 1'b1;
            end
        end
        else
        begin
            res_first.read_data  = rd;
            res_first.unmodelled = um;
            res_first.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr0_reg   <= smrb_pkg::CR0_RESET;
            cr1_reg   <= '0;
            cpsr_reg  <= '0;
            imsc_reg  <= '0;
            icr_reg   <= '0;
            dmacr_reg <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < smrb_pkg::RX_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            cr0_reg   <= cr0_next;
            cr1_reg   <= cr1_next;
            cpsr_reg  <= cpsr_next;
            imsc_reg  <= imsc_next;
            icr_reg   <= icr_next;
            dmacr_reg <= dmacr_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (push)
            begin
                store_reg[tail_idx] <= smrb_pkg::RX_PUSH_VALUE;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smrb_out_buf.sv @@
`default_nettype none

module smrb_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire smrb_pkg::res_t load_first,
    input  wire smrb_pkg::res_t load_second,
    input  wire logic           load_two,
    output logic                can_load,
    output logic                out_valid,
    input  wire logic           out_ready,
    output smrb_pkg::res_t      out_word
);

    logic           valid_reg;
    logic           pend_reg;
    smrb_pkg::res_t cur_reg;
    smrb_pkg::res_t second_reg;
    logic           take;

    assign take      = valid_reg && out_ready;
    // empty after this edge: nothing held, or the last word leaves now
    assign can_load  = !valid_reg || (take && !pend_reg);
    assign out_valid = valid_reg;
    assign out_word  = cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            pend_reg  <= load_two;
        end
        else if (take)
        begin
            valid_reg <= pend_reg;
            pend_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg    <= load_first;
            second_reg <= load_second;
        end
        else if (take && pend_reg)
        begin
            cur_reg <= second_reg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/spi_master_register_block.sv @@
`default_nettype none

// spi master register block: one bus access per input word (mode 0 read,
// 1 write, 14-bit byte offset, 32-bit write data), one or two result words
// out. map: 0x00 cr0 (resets to 7), 0x04 cr1, 0x08 data, 0x0c status,
// 0x10 prescale, 0x14 int mask, 0x18 raw int, 0x1c masked int, 0x20 int
// clear, 0x24 dma control. a data write sends its byte, or high then low
// byte when cr0[3:0] selects frames wider than 8 bits, and pushes a zero
// entry into the 8-deep receive fifo (overrun flagged on the last word when
// full). a data read pops the fifo, 0 when empty. any other offset, or a
// write to a read-only one, is flagged unmodelled. throughput is one access
// per cycle while out_ready is high, except a wide-frame data write, which
// holds the output register until both of its words are taken. an access
// passes through the input register, then the result register. the input
// register, when empty, takes a new word while a result waits at the output.
module spi_master_register_block (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [13:0] offset,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             rx_overrun,
    output logic             unmodelled,
    output logic             last
);

    // input register
    logic           req_valid_reg;
    smrb_pkg::req_t req_reg;

    logic           fire;
    logic           can_load;
    smrb_pkg::res_t res_first;
    smrb_pkg::res_t res_second;
    logic           two_results;
    smrb_pkg::res_t out_word;

    // the held access executes once the output register will be free
    assign fire     = req_valid_reg && can_load;
    assign in_ready = !req_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg.mode       <= mode;
            req_reg.offset     <= offset;
            req_reg.write_data <= write_data;
        end
    end

    // control words, receive fifo and decode
    smrb_regfile u_regfile (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .req         (req_reg),
        .res_first   (res_first),
        .res_second  (res_second),
        .two_results (two_results)
    );

    // result register, holds the second byte of a wide frame
    smrb_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .load_first  (res_first),
        .load_second (res_second),
        .load_two    (two_results),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

    assign read_data  = out_word.read_data;
    assign out_byte   = out_word.out_byte;
    assign byte_valid = out_word.byte_valid;
    assign rx_overrun = out_word.rx_overrun;
    assign unmodelled = out_word.unmodelled;
    assign last       = out_word.last;

endmodule

`default_nettype wire

@@ test/spi_master_register_block_test.sv @@
`default_nettype none

// shadow copy of the register block: predicts the result words of each
// accepted access and checks the words that come out against them
class spi_regs_shadow;
    logic [31:0]     cr0;
    logic [31:0]     cr1;
    logic [31:0]     cpsr;
    logic [31:0]     imsc;
    logic [31:0]     icr;
    logic [31:0]     dmacr;
    logic [15:0]     rx_store [smrb_pkg::RX_DEPTH];
    int unsigned     rx_head;
    int unsigned     rx_fill;
    smrb_pkg::res_t  expected_words [$];
    int              mismatches;

    localparam logic [31:0] STATUS_NOT_EMPTY = 32'h0000_0004;
    localparam logic [31:0] STATUS_FULL      = 32'h0000_0008;
    localparam logic [3:0]  WIDE_FRAME_MIN   = 4'd8;

    function new();
        cr0   = smrb_pkg::CR0_RESET;
        cr1   = '0;
        cpsr  = '0;
        imsc  = '0;
        icr   = '0;
        dmacr = '0;
        foreach (rx_store[i]) rx_store[i] = '0;
        rx_head    = 0;
        rx_fill    = 0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void add_word(logic [31:0] rd, logic [7:0] b, logic bv, logic ov,
                           logic um, logic lst);
        smrb_pkg::res_t w;
        w.read_data  = rd;
        w.out_byte   = b;
        w.byte_valid = bv;
        w.rx_overrun = ov;
        w.unmodelled = um;
        w.last       = lst;
        expected_words.push_back(w);
    endfunction

    // returns 1 when the entry was dropped
    function logic rx_push();
        if (rx_fill >= smrb_pkg::RX_DEPTH)
            return 1'b1;
        rx_store[(rx_head + rx_fill) % smrb_pkg::RX_DEPTH] = smrb_pkg::RX_PUSH_VALUE;
        rx_fill++;
        return 1'b0;
    endfunction

    function logic [31:0] rx_pop();
        logic [15:0] v;
        if (rx_fill == 0)
            return '0;
        v = rx_store[rx_head];
        rx_head = (rx_head + 1) % smrb_pkg::RX_DEPTH;
        rx_fill--;
        return {16'h0000, v};
    endfunction

    function void note_access(logic m, logic [13:0] off, logic [31:0] wd);
        logic [31:0] rd;
        logic [31:0] ris;
        logic        um;
        logic        ov;
        rd  = '0;
        um  = 1'b0;
        ris = (rx_fill != 0) ? smrb_pkg::RX_INT_BIT : 32'h0;
        if (m == smrb_pkg::MODE_READ)
        begin
            case (off)
                smrb_pkg::OFS_CR0:    rd = cr0;
                smrb_pkg::OFS_CR1:    rd = cr1;
                smrb_pkg::OFS_DATA:   rd = rx_pop();
                smrb_pkg::OFS_STATUS: rd = smrb_pkg::STATUS_FIXED
                                      | ((rx_fill != 0) ? STATUS_NOT_EMPTY : 32'h0)
                                      | ((rx_fill >= smrb_pkg::RX_DEPTH) ? STATUS_FULL : 32'h0);
                smrb_pkg::OFS_CPSR:   rd = cpsr;
                smrb_pkg::OFS_IMSC:   rd = imsc;
                smrb_pkg::OFS_RIS:    rd = ris;
                smrb_pkg::OFS_MIS:    rd = ris & imsc;
                smrb_pkg::OFS_ICR:    rd = icr;
                smrb_pkg::OFS_DMACR:  rd = dmacr;
                default:              um = 1'b1;
            endcase
            add_word(rd, 8'h00, 1'b0, 1'b0, um, 1'b1);
            return;
        end
        case (off)
            smrb_pkg::OFS_CR0:   cr0 = wd;
            smrb_pkg::OFS_CR1:   cr1 = wd;
            smrb_pkg::OFS_DATA:
            begin
                ov = rx_push();
                if (cr0[3:0] >= WIDE_FRAME_MIN)
                begin
                    add_word('0, wd[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
                    add_word('0, wd[7:0], 1'b1, ov, 1'b0, 1'b1);
                end
                else
                begin
                    add_word('0, wd[7:0], 1'b1, ov, 1'b0, 1'b1);
                end
                return;
            end
            smrb_pkg::OFS_CPSR:  cpsr = wd;
            smrb_pkg::OFS_IMSC:  imsc = wd;
            smrb_pkg::OFS_ICR:   icr = wd;
            smrb_pkg::OFS_DMACR: dmacr = wd;
            default:             um = 1'b1;
        endcase
        add_word('0, 8'h00, 1'b0, 1'b0, um, 1'b1);
    endfunction

    function void check_word(smrb_pkg::res_t got);
        smrb_pkg::res_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word, expected none actual %h", $time, got);
            mismatches++;
            return;
        end
        want = expected_words.pop_front();
        if (got.read_data !== want.read_data)
        begin
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, got.read_data);
            mismatches++;
        end
        if (got.out_byte !== want.out_byte)
        begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.byte_valid !== want.byte_valid)
        begin
            $display("%0t: byte_valid expected %b actual %b", $time,
                     want.byte_valid, got.byte_valid);
            mismatches++;
        end
        if (got.rx_overrun !== want.rx_overrun)
        begin
            $display("%0t: rx_overrun expected %b actual %b", $time,
                     want.rx_overrun, got.rx_overrun);
            mismatches++;
        end
        if (got.unmodelled !== want.unmodelled)
        begin
            $display("%0t: unmodelled expected %b actual %b", $time,
                     want.unmodelled, got.unmodelled);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module spi_master_register_block_test;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: about 1200 accesses, two words each at worst, with
    // heavy stalls on both sides and one long receiver hold
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_ACCESSES = 400;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [13:0] offset;
    logic [31:0] write_data;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        rx_overrun;
    logic        unmodelled;
    logic        last;

    spi_regs_shadow shadow = new();

    // idle odds in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    // asks the receiver for one long hold-off
    bit hold_req;
    int cycle_count;

    spi_master_register_block u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .offset     (offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .rx_overrun (rx_overrun),
        .unmodelled (unmodelled),
        .last       (last)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: every accepted word goes to the shadow for checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_word({read_data, out_byte, byte_valid, rx_overrun,
                               unmodelled, last});
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one access and wait for it to be taken; entered and left at a
    // falling edge, valid stays high on return so back-to-back words flow
    task automatic send_access(logic m, logic [13:0] off, logic [31:0] wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        offset     <= off;
        write_data <= wd;
        do @(posedge clk); while (!in_ready);
        shadow.note_access(m, off, wd);
        @(negedge clk);
    endtask

    // drop valid and wait until every predicted word has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge clk);
    endtask

    task automatic run_directed();
        // reset values, and a pop of the empty fifo
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_CR0, '0);
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_DATA, '0);
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_STATUS, '0);
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_RIS, '0);
        // sixteen bit frames: two bytes, high first
        send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_CR0, 32'h0000_000F);
        send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_DATA, 32'hFFFF_FFFF);
        // back to eight bit frames with every upper bit set
        send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_CR0, 32'hFFFF_FFF0);
        send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_DATA, 32'hFFFF_FFFF);
        // fill the fifo, the last write overruns
        for (int i = 0; i < smrb_pkg::RX_DEPTH - 1; i++)
            send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_DATA, 32'h0000_0000);
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_STATUS, '0);
        send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_IMSC, 32'hFFFF_FFFF);
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_MIS, '0);
        send_access(smrb_pkg::MODE_READ, smrb_pkg::OFS_DATA, '0);
        // write to a read-only register, top of window, unaligned offset
        send_access(smrb_pkg::MODE_WRITE, smrb_pkg::OFS_STATUS, 32'hFFFF_FFFF);
        send_access(smrb_pkg::MODE_WRITE, 14'h3FFF, 32'hFFFF_FFFF);
        send_access(smrb_pkg::MODE_READ, 14'h0001, '0);
    endtask

    task automatic run_random(int count);
        int          write_bias;
        int          r;
        logic        m;
        logic [13:0] off;
        logic [31:0] wd;
        write_bias = 50;
        for (int k = 0; k < count; k++)
        begin
            // shift the push/pop balance now and then so the fifo swings
            // between empty and full
            if (k % 50 == 0)
            begin
                case ($urandom_range(2))
                    0: write_bias = 25;
                    1: write_bias = 50;
                    default: write_bias = 80;
                endcase
            end
            r = $urandom_range(99);
            m = $urandom_range(1) ? smrb_pkg::MODE_WRITE : smrb_pkg::MODE_READ;
            if (r < 45)
            begin
                off = smrb_pkg::OFS_DATA;
                m   = ($urandom_range(99) < write_bias) ? smrb_pkg::MODE_WRITE
                                                         : smrb_pkg::MODE_READ;
            end
            else if (r < 85)
            begin
                case ($urandom_range(9))
                    0: off = smrb_pkg::OFS_CR0;
                    1: off = smrb_pkg::OFS_CR1;
                    2: off = smrb_pkg::OFS_DATA;
                    3: off = smrb_pkg::OFS_STATUS;
                    4: off = smrb_pkg::OFS_CPSR;
                    5: off = smrb_pkg::OFS_IMSC;
                    6: off = smrb_pkg::OFS_RIS;
                    7: off = smrb_pkg::OFS_MIS;
                    8: off = smrb_pkg::OFS_ICR;
                    default: off = smrb_pkg::OFS_DMACR;
                endcase
            end
            else if (r < 93)
            begin
                // anywhere in the window
                off = 14'($urandom_range(16383));
            end
            else
            begin
                // unaligned or just past the map
                off = 14'($urandom_range(9) * 4 + $urandom_range(1, 3));
            end
            case ($urandom_range(9))
                0: wd = 32'h0000_0000;
                1: wd = 32'hFFFF_FFFF;
                default: wd = $urandom;
            endcase
            send_access(m, off, wd);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = smrb_pkg::MODE_READ;
        offset        = '0;
        write_data    = '0;
        hold_req      = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 21;
        recv_idle_pct = 46;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(PHASE_ACCESSES);
        // sender pauses until everything is out
        drain_results();

        send_idle_pct = 46;
        recv_idle_pct = 21;
        run_random(PHASE_ACCESSES);
        drain_results();

        // no idling; receiver holds off once while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_random(PHASE_ACCESSES);
        drain_results();

        // catch any stray words after the last expected one
        repeat (TAIL_CYCLES) @(negedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
